/* hw/rtl/gbi_pkg.sv */
// Shared types and constants of the grid bilinear interpolator.
`timescale 1ns / 1ps

package gbi_pkg;

	// Request command codes
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Fixed field widths
	localparam int CFG_W    = 7;
	localparam int QUERY_W  = 14;
	localparam int IDX_IN_W = 6;
	localparam int SAMPLE_W = 32;
	localparam int OUT_W    = 32;

	// Configuration register file
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Query sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A0,
		ST_RD_A1,
		ST_RD_B0,
		ST_RD_B1,
		ST_MUL_B1,
		ST_ROW_B,
		ST_MUL_YA,
		ST_MUL_YB,
		ST_SUM,
		ST_ROUND
	} state_t;

	// Blend datapath controls, one step per cycle
	typedef struct packed {
		logic mul_x;
		logic x_hi;
		logic row_a_en;
		logic row_b_en;
		logic row_first;
		logic mul_y;
		logic y_hi;
		logic sum_en;
		logic sum_first;
	} blend_ctl_t;

endpackage

/* hw/rtl/gbi_grid_mem.sv */
// Grid sample memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module gbi_grid_mem #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic signed [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0]        raddr,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	// Write one sample, read one sample per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/gbi_blend.sv */
// Bilinear blend datapath: weighted row sums, column blend and final rounding.
`timescale 1ns / 1ps

module gbi_blend #(
	parameter int VALUE_BITS = 32,
	parameter int FRAC_BITS  = 8
) (
	input  logic                             clk,
	input  gbi_pkg::blend_ctl_t              ctl,
	input  logic signed [VALUE_BITS-1:0]     rd_data,
	input  logic [FRAC_BITS-1:0]             fx,
	input  logic [FRAC_BITS-1:0]             fy,
	output logic [gbi_pkg::OUT_W-1:0]        result
);
	import gbi_pkg::*;

	localparam int WW = FRAC_BITS + 2;
	localparam int PW = VALUE_BITS + FRAC_BITS + 2;
	localparam int YW = PW + FRAC_BITS + 2;

	logic signed [WW-1:0] one_w;
	logic signed [WW-1:0] fx_w;
	logic signed [WW-1:0] fy_w;
	logic signed [WW-1:0] wx;
	logic signed [WW-1:0] wy;
	logic signed [PW-1:0] row_sel;
	logic signed [PW-1:0] prod_x_q;
	logic signed [PW-1:0] row_a_q;
	logic signed [PW-1:0] row_b_q;
	logic signed [YW-1:0] prod_y_q;
	logic signed [YW-1:0] sum_q;
	logic signed [YW-1:0] half;
	logic signed [YW-1:0] rnd;
	logic signed [YW-1:0] quo;

	// Weights: the fraction or its complement to one
	assign one_w = $signed(WW'(1) << FRAC_BITS);
	assign fx_w  = $signed({2'b00, fx});
	assign fy_w  = $signed({2'b00, fy});
	assign wx    = ctl.x_hi ? fx_w : one_w - fx_w;
	assign wy    = ctl.y_hi ? fy_w : one_w - fy_w;
	assign row_sel = ctl.y_hi ? row_b_q : row_a_q;

	// Multiply and accumulate, one step per cycle
	always_ff @(posedge clk) begin
		if (ctl.mul_x) begin
			prod_x_q <= rd_data * wx;
		end
		if (ctl.row_a_en) begin
			row_a_q <= ctl.row_first ? prod_x_q : row_a_q + prod_x_q;
		end
		if (ctl.row_b_en) begin
			row_b_q <= ctl.row_first ? prod_x_q : row_b_q + prod_x_q;
		end
		if (ctl.mul_y) begin
			prod_y_q <= row_sel * wy;
		end
		if (ctl.sum_en) begin
			sum_q <= ctl.sum_first ? prod_y_q : sum_q + prod_y_q;
		end
	end

	// Round half up and drop the weight scale
	assign half   = $signed(YW'(1) << (2 * FRAC_BITS - 1));
	assign rnd    = sum_q + half;
	assign quo    = rnd >>> (2 * FRAC_BITS);
	assign result = OUT_W'(quo);

endmodule

/* hw/rtl/grid_bilinear_interpolator_unit.sv */
// Top level of the grid bilinear interpolator: request decode, sequencer, output register.
`timescale 1ns / 1ps
//
// Holds a GRID_COLS x GRID_ROWS grid of signed samples and answers bilinear queries.
// Input channel (in_valid / in_stall): command 0 writes sample_value at grid_col,
// grid_row and returns nothing; command 1 queries at query_x, query_y (FRAC_BITS
// fraction bits) and returns one interpolated_value with its edge_clamped flag.
// Output channel (out_valid / out_stall) carries one result per query.
// Writes stream at one per cycle whenever no query is in flight.
// A query stalls the input from acceptance until its result is loaded: the grid memory has a
// single read port, so the four neighbors are fetched one per cycle, followed by
// the row blend, column blend and rounding steps. No new request is taken
// while a query is in flight.
// While a result waits under out_stall the block keeps taking requests; a new
// query finishes its math and holds in its last step until the output frees up.
// Reset clears the sequencer and output valid and sets columns_in_use and
// rows_in_use to 64. Grid contents are not cleared: write before reading.
// columns_in_use and rows_in_use sit on the APB port at 0x0 and 0x4.
//
module grid_bilinear_interpolator_unit #(
	parameter int GRID_COLS  = 64,
	parameter int GRID_ROWS  = 64,
	parameter int FRAC_BITS  = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                command,
	input  logic [gbi_pkg::IDX_IN_W-1:0]        grid_col,
	input  logic [gbi_pkg::IDX_IN_W-1:0]        grid_row,
	input  logic signed [gbi_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [gbi_pkg::QUERY_W-1:0]         query_x,
	input  logic [gbi_pkg::QUERY_W-1:0]         query_y,
	// Result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [gbi_pkg::OUT_W-1:0]    interpolated_value,
	output logic                                edge_clamped,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gbi_pkg::PADDR_W-1:0]         paddr,
	input  logic [gbi_pkg::PDATA_W-1:0]         pwdata,
	output logic [gbi_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);
	import gbi_pkg::*;

	localparam int DEPTH  = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int QI_W   = (QUERY_W > FRAC_BITS) ? QUERY_W - FRAC_BITS : 1;
	localparam int CC_W   = $clog2(GRID_COLS + 1);
	localparam int RC_W   = $clog2(GRID_ROWS + 1);
	localparam int XM_W   = (QI_W > CFG_W) ? QI_W : CFG_W;
	localparam int YM_W   = (QI_W > CFG_W) ? QI_W : CFG_W;
	localparam int XW     = ((XM_W > CC_W) ? XM_W : CC_W) + 1;
	localparam int YW     = ((YM_W > RC_W) ? YM_W : RC_W) + 1;
	localparam int WCW    = ((IDX_IN_W > CC_W) ? IDX_IN_W : CC_W) + 1;
	localparam int WRW    = ((IDX_IN_W > RC_W) ? IDX_IN_W : RC_W) + 1;

	state_t state_q;
	state_t state_d;
	blend_ctl_t ctl;

	logic [CFG_W-1:0] columns_in_use_q;
	logic [CFG_W-1:0] rows_in_use_q;

	logic in_accept;
	logic cfg_write;
	logic mem_we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic signed [VALUE_BITS-1:0] rd_data;
	logic [COL_W-1:0] rd_col;
	logic [ROW_W-1:0] rd_row;

	logic [XW-1:0] cols_ext;
	logic [XW-1:0] cols_sat;
	logic [XW-1:0] last_col;
	logic [XW-1:0] x1_ext;
	logic [XW-1:0] x1_inc;
	logic [XW-1:0] x1_cl;
	logic [XW-1:0] x2_cl;
	logic          clamp_x;
	logic [YW-1:0] rows_ext;
	logic [YW-1:0] rows_sat;
	logic [YW-1:0] last_row;
	logic [YW-1:0] y1_ext;
	logic [YW-1:0] y1_inc;
	logic [YW-1:0] y1_cl;
	logic [YW-1:0] y2_cl;
	logic          clamp_y;

	logic [COL_W-1:0] x1_q;
	logic [COL_W-1:0] x2_q;
	logic [ROW_W-1:0] y1_q;
	logic [ROW_W-1:0] y2_q;
	logic [FRAC_BITS-1:0] fx_q;
	logic [FRAC_BITS-1:0] fy_q;
	logic clamp_q;

	logic res_load;
	logic [OUT_W-1:0] result;
	logic out_valid_q;
	logic signed [OUT_W-1:0] value_q;
	logic clamped_q;

	function automatic logic [ADDR_W-1:0] grid_addr(
		input logic [COL_W-1:0] c,
		input logic [ROW_W-1:0] r
	);
		grid_addr = ADDR_W'(r) * ADDR_W'(GRID_COLS) + ADDR_W'(c);
	endfunction

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);

	// Configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_in_use_q <= CFG_RESET;
			rows_in_use_q    <= CFG_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_COLUMNS: columns_in_use_q <= pwdata[CFG_W-1:0];
				REG_ROWS:    rows_in_use_q    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLUMNS: prdata = PDATA_W'(columns_in_use_q);
			REG_ROWS:    prdata = PDATA_W'(rows_in_use_q);
			default:     prdata = '0;
		endcase
	end

	// Last column and row in use, then clamp the query neighbors
	always_comb begin
		cols_ext = XW'(columns_in_use_q);
		if (cols_ext < XW'(2)) begin
			cols_sat = XW'(2);
		end else if (cols_ext > XW'(GRID_COLS)) begin
			cols_sat = XW'(GRID_COLS);
		end else begin
			cols_sat = cols_ext;
		end
		last_col = cols_sat - XW'(1);
		x1_ext   = XW'(QI_W'(query_x >> FRAC_BITS));
		x1_inc   = x1_ext + XW'(1);
		clamp_x  = (x1_inc > last_col);
		x2_cl    = clamp_x ? last_col : x1_inc;
		x1_cl    = (x1_ext > last_col) ? last_col : x1_ext;

		rows_ext = YW'(rows_in_use_q);
		if (rows_ext < YW'(2)) begin
			rows_sat = YW'(2);
		end else if (rows_ext > YW'(GRID_ROWS)) begin
			rows_sat = YW'(GRID_ROWS);
		end else begin
			rows_sat = rows_ext;
		end
		last_row = rows_sat - YW'(1);
		y1_ext   = YW'(QI_W'(query_y >> FRAC_BITS));
		y1_inc   = y1_ext + YW'(1);
		clamp_y  = (y1_inc > last_row);
		y2_cl    = clamp_y ? last_row : y1_inc;
		y1_cl    = (y1_ext > last_row) ? last_row : y1_ext;
	end

	// Capture a query's neighbors and fractions
	always_ff @(posedge clk) begin
		if (in_accept && command == CMD_QUERY) begin
			x1_q    <= COL_W'(x1_cl);
			x2_q    <= COL_W'(x2_cl);
			y1_q    <= ROW_W'(y1_cl);
			y2_q    <= ROW_W'(y2_cl);
			fx_q    <= FRAC_BITS'(query_x);
			fy_q    <= FRAC_BITS'(query_y);
			clamp_q <= clamp_x || clamp_y;
		end
	end

	// Sample writes go straight to the grid; out-of-grid writes are dropped
	assign mem_we = in_accept && (command == CMD_WRITE)
		&& (WCW'(grid_col) < WCW'(GRID_COLS))
		&& (WRW'(grid_row) < WRW'(GRID_ROWS));
	assign waddr  = grid_addr(COL_W'(grid_col), ROW_W'(grid_row));
	assign raddr  = grid_addr(rd_col, rd_row);

	gbi_grid_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (VALUE_BITS)
	) u_grid_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (VALUE_BITS'(sample_value)),
		.raddr (raddr),
		.rdata (rd_data)
	);

	gbi_blend #(
		.VALUE_BITS (VALUE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_blend (
		.clk     (clk),
		.ctl     (ctl),
		.rd_data (rd_data),
		.fx      (fx_q),
		.fy      (fy_q),
		.result  (result)
	);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, read address and blend controls
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		rd_col   = x1_q;
		rd_row   = y1_q;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept && command == CMD_QUERY) begin
					state_d = ST_RD_A0;
				end
			end
			ST_RD_A0: begin
				state_d = ST_RD_A1;
			end
			ST_RD_A1: begin
				rd_col    = x2_q;
				ctl.mul_x = 1'b1;
				state_d   = ST_RD_B0;
			end
			ST_RD_B0: begin
				rd_row        = y2_q;
				ctl.mul_x     = 1'b1;
				ctl.x_hi      = 1'b1;
				ctl.row_a_en  = 1'b1;
				ctl.row_first = 1'b1;
				state_d       = ST_RD_B1;
			end
			ST_RD_B1: begin
				rd_col       = x2_q;
				rd_row       = y2_q;
				ctl.mul_x    = 1'b1;
				ctl.row_a_en = 1'b1;
				state_d      = ST_MUL_B1;
			end
			ST_MUL_B1: begin
				ctl.mul_x     = 1'b1;
				ctl.x_hi      = 1'b1;
				ctl.row_b_en  = 1'b1;
				ctl.row_first = 1'b1;
				state_d       = ST_ROW_B;
			end
			ST_ROW_B: begin
				ctl.row_b_en = 1'b1;
				state_d      = ST_MUL_YA;
			end
			ST_MUL_YA: begin
				ctl.mul_y = 1'b1;
				state_d   = ST_MUL_YB;
			end
			ST_MUL_YB: begin
				ctl.mul_y     = 1'b1;
				ctl.y_hi      = 1'b1;
				ctl.sum_en    = 1'b1;
				ctl.sum_first = 1'b1;
				state_d       = ST_SUM;
			end
			ST_SUM: begin
				ctl.sum_en = 1'b1;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				// Hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			value_q   <= $signed(result);
			clamped_q <= clamp_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign interpolated_value = value_q;
	assign edge_clamped       = clamped_q;

	// A grid write never overlaps a query in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE))
		else $error("grid write while a query is in flight");

	// An accepted query starts the neighbor fetch next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && command == CMD_QUERY) |=> (state_q == ST_RD_A0))
		else $error("query accepted without starting the fetch");

	// A result appears only out of the rounding step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ROUND))
		else $error("result valid without a finished query");

	// The rounding step never overwrites a result still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!out_valid_q || !out_stall))
		else $error("pending result overwritten");

endmodule
